// File: rtl/sng_pkg.sv
// ----------------------------------------------------------------------------
// sng_pkg: shared types and constants for the spectral noise gain engine
// Field widths, register codes, reset values and the per-bin state row.
// ----------------------------------------------------------------------------
package sng_pkg;

   localparam int NumBinsDefault = 257;
   localparam int IndexWidth     = 9;
   localparam int SampleWidth    = 24;
   localparam int GainWidth      = 16;
   localparam int PowerWidth     = 48;
   localparam int PeriodWidth    = 12;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 16;
   localparam int AccWidth       = 66;
   localparam int QueueDepth     = 2;

   localparam logic [PowerWidth-1:0]  PowerOne = 48'h4000_0000_0000;
   localparam logic [PowerWidth-1:0]  PowerEps = 48'd70;
   localparam logic [PowerWidth-1:0]  PowerMax = 48'hFFFF_FFFF_FFFF;
   localparam logic [GainWidth-1:0]   PowerSmoothingReset = 16'd55706;
   localparam logic [GainWidth-1:0]   NoiseBiasReset      = 16'd6554;
   localparam logic [GainWidth-1:0]   PriorSmoothingReset = 16'd64225;
   localparam logic [GainWidth-1:0]   GainFloorReset      = 16'd5243;
   localparam logic [PeriodWidth-1:0] TrackerPeriodReset  = 12'd240;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_POWER_SMOOTHING = 3'd0,
      CSR_NOISE_BIAS      = 3'd1,
      CSR_PRIOR_SMOOTHING = 3'd2,
      CSR_GAIN_FLOOR      = 3'd3,
      CSR_TRACKER_PERIOD  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GainWidth-1:0] power_smoothing;
      logic [GainWidth-1:0] noise_bias;
      logic [GainWidth-1:0] prior_smoothing;
      logic [GainWidth-1:0] gain_floor;
   } cfg_type;

   typedef struct packed {
      logic [IndexWidth-1:0]         index;
      logic signed [SampleWidth-1:0] re;
      logic signed [SampleWidth-1:0] im;
      logic                          in_range;
      logic                          swap;
   } item_type;

   typedef struct packed {
      logic [PowerWidth-1:0]  smoothed;
      logic [PowerWidth-1:0]  running_min;
      logic [PowerWidth-1:0]  spare_min;
      logic [PowerWidth-1:0]  noise;
      logic [SampleWidth-1:0] clean;
   } row_type;

   // magnitude of a two's complement sample; the most negative code maps to 2^23
   function automatic logic [SampleWidth-1:0] mag24(input logic [SampleWidth-1:0] v);
      logic [SampleWidth-1:0] m;
      m = v[SampleWidth-1] ? (SampleWidth'(0) - v) : v;
      return m;
   endfunction

endpackage

// File: rtl/sng_ram.sv
// ----------------------------------------------------------------------------
// sng_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sng_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sng_fifo.sv
// ----------------------------------------------------------------------------
// sng_fifo: short item queue between front and back
// Register-based FIFO that lets each side stall on its own.
// ----------------------------------------------------------------------------
module sng_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  sng_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop,
   output sng_pkg::item_type pop_item
);

   localparam int PtrWidth = $clog2(sng_pkg::QueueDepth);

   sng_pkg::item_type      entry_ff [sng_pkg::QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff;
   logic [PtrWidth-1:0]    rd_ptr_ff;
   logic [PtrWidth:0]      count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != (PtrWidth+1)'(sng_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(sng_pkg::QueueDepth-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(sng_pkg::QueueDepth-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/sng_front.sv
// ----------------------------------------------------------------------------
// sng_front: input acceptance, bin classification and frame counting
// Holds the control registers, checks the bin range and decides per frame
// whether the minimum trackers swap.
// ----------------------------------------------------------------------------
module sng_front #(
   parameter int NumBins = sng_pkg::NumBinsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sng_pkg::IndexWidth-1:0]      req_bin_index,
   input  logic signed [sng_pkg::SampleWidth-1:0] req_bin_real,
   input  logic signed [sng_pkg::SampleWidth-1:0] req_bin_imag,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sng_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [sng_pkg::CsrDataWidth-1:0]    csr_data,
   input  logic                                clear_busy,
   output sng_pkg::cfg_type                    cfg,
   output logic                                push_valid,
   input  logic                                push_ready,
   output sng_pkg::item_type                   push_item
);

   sng_pkg::cfg_type                    cfg_ff;
   logic [sng_pkg::PeriodWidth-1:0]     period_ff;
   logic [sng_pkg::PeriodWidth-1:0]     countdown_ff;
   logic                                swap_ff;
   logic                                accept;
   logic                                in_range;
   logic                                frame_start;
   logic                                swap_next;

   assign csr_ready   = 1'b1;
   assign cfg         = cfg_ff;
   assign push_valid  = req_valid && !clear_busy;
   assign req_ready   = push_ready && !clear_busy;
   assign accept      = req_valid && req_ready;
   assign in_range    = (32'(req_bin_index) < NumBins);
   assign frame_start = in_range && (req_bin_index == '0);
   assign swap_next   = (countdown_ff <= sng_pkg::PeriodWidth'(1));

   always_comb begin
      push_item.index    = req_bin_index;
      push_item.re       = req_bin_real;
      push_item.im       = req_bin_imag;
      push_item.in_range = in_range;
      push_item.swap     = frame_start ? swap_next : swap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_smoothing <= sng_pkg::PowerSmoothingReset;
         cfg_ff.noise_bias      <= sng_pkg::NoiseBiasReset;
         cfg_ff.prior_smoothing <= sng_pkg::PriorSmoothingReset;
         cfg_ff.gain_floor      <= sng_pkg::GainFloorReset;
         period_ff              <= sng_pkg::TrackerPeriodReset;
         countdown_ff           <= sng_pkg::TrackerPeriodReset;
         swap_ff                <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (sng_pkg::csr_index_type'(csr_index))
               sng_pkg::CSR_POWER_SMOOTHING: cfg_ff.power_smoothing <= csr_data;
               sng_pkg::CSR_NOISE_BIAS:      cfg_ff.noise_bias      <= csr_data;
               sng_pkg::CSR_PRIOR_SMOOTHING: cfg_ff.prior_smoothing <= csr_data;
               sng_pkg::CSR_GAIN_FLOOR:      cfg_ff.gain_floor      <= csr_data;
               sng_pkg::CSR_TRACKER_PERIOD:  period_ff <= csr_data[sng_pkg::PeriodWidth-1:0];
               default: ;
            endcase
         end
         // reload on the last frame of a period, count down otherwise
         if (accept && frame_start) begin
            swap_ff      <= swap_next;
            countdown_ff <= swap_next ? period_ff : countdown_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/sng_back.sv
// ----------------------------------------------------------------------------
// sng_back: per-bin noise tracking and Wiener gain sequencer
// Shared multiply-accumulate, bit-serial square root and restoring divider
// step through one bin's read-modify-write of its state row.
// ----------------------------------------------------------------------------
module sng_back #(
   parameter int NumBins = sng_pkg::NumBinsDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sng_pkg::cfg_type                       cfg,
   input  logic                                   head_valid,
   input  sng_pkg::item_type                      head_item,
   output logic                                   pop,
   output logic                                   clear_busy,
   output logic                                   ram_wr_en,
   output logic [$clog2(NumBins)-1:0]             ram_wr_addr,
   output sng_pkg::row_type                       ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [$clog2(NumBins)-1:0]             ram_rd_addr,
   input  sng_pkg::row_type                       ram_rd_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sng_pkg::IndexWidth-1:0]         rsp_out_index,
   output logic signed [sng_pkg::SampleWidth-1:0] rsp_out_real,
   output logic signed [sng_pkg::SampleWidth-1:0] rsp_out_imag,
   output logic [sng_pkg::GainWidth-1:0]          rsp_bin_gain
);

   localparam int AddrWidth = $clog2(NumBins);
   localparam int PW = sng_pkg::PowerWidth;
   localparam int SW = sng_pkg::SampleWidth;
   localparam int GW = sng_pkg::GainWidth;
   localparam int AW = sng_pkg::AccWidth;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_P1, S_SP0, S_SP1, S_SP2, S_SP3, S_MIN,
      S_B0, S_B1, S_B2, S_X0, S_X1, S_X2, S_X3, S_X4, S_DIV, S_DIVI,
      S_GAIN, S_C0, S_C1, S_C2, S_C3, S_WB
   } state_type;

   state_type              state_ff;
   logic [AddrWidth-1:0]   clr_cnt_ff;
   sng_pkg::item_type      cur_ff;
   sng_pkg::row_type       row_ff;
   logic [PW-1:0]          p_ff;
   logic [PW-1:0]          cc_ff;
   logic [PW-1:0]          n_ff;
   logic [PW-1:0]          ex_ff;
   logic [AW-1:0]          acc_ff;
   logic [PW:0]            rem_ff;
   logic [PW:0]            den_ff;
   logic [GW-1:0]          q_ff;
   logic [3:0]             div_cnt_ff;
   logic [GW-1:0]          g_ff;
   logic [SW-1:0]          ore_ff;
   logic [SW-1:0]          oim_ff;
   logic [PW-1:0]          sq_v_ff;
   logic [PW-1:0]          sq_r_ff;
   logic [PW-1:0]          sq_bit_ff;
   logic                   rsp_valid_ff;
   logic [sng_pkg::IndexWidth-1:0] rsp_index_ff;
   logic [SW-1:0]          rsp_real_ff;
   logic [SW-1:0]          rsp_imag_ff;
   logic [GW-1:0]          rsp_gain_ff;

   logic [SW-1:0]          mul_a;
   logic [SW-1:0]          mul_b;
   logic [2*SW-1:0]        prod;
   logic                   acc_en;
   logic                   acc_clear;
   logic                   acc_hi;
   logic [AW-1:0]          acc_in;
   logic [SW-1:0]          mag_re;
   logic [SW-1:0]          mag_im;
   logic [GW:0]            ps_inv;
   logic [GW:0]            d_inv;
   logic [PW-1:0]          sp_new;
   logic [PW-1:0]          x_val;
   logic [51:0]            bias_t;
   logic [PW+1:0]          rem2;
   logic [PW-1:0]          sq_trial;
   logic                   out_free;
   logic [SW-1:0]          m_re;
   logic [SW-1:0]          m_im;
   sng_pkg::row_type       row_reset;

   assign mag_re   = sng_pkg::mag24(cur_ff.re);
   assign mag_im   = sng_pkg::mag24(cur_ff.im);
   assign ps_inv   = 17'h10000 - {1'b0, cfg.power_smoothing};
   assign d_inv    = 17'h10000 - {1'b0, cfg.prior_smoothing};
   assign prod     = mul_a * mul_b;
   assign acc_in   = (acc_clear ? '0 : acc_ff) + (AW'(prod) << (acc_hi ? SW : 0));
   assign sp_new   = acc_ff[GW +: PW];
   assign x_val    = acc_ff[GW +: PW];
   assign bias_t   = acc_ff[63:12];
   assign rem2     = {rem_ff, 1'b0};
   assign sq_trial = sq_r_ff + sq_bit_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign m_re     = acc_ff[SW+GW-1:GW];
   assign m_im     = acc_ff[SW+GW-1:GW];

   always_comb begin
      row_reset.smoothed    = '0;
      row_reset.running_min = sng_pkg::PowerOne;
      row_reset.spare_min   = sng_pkg::PowerOne;
      row_reset.noise       = '0;
      row_reset.clean       = '0;
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      acc_en    = 1'b1;
      acc_clear = 1'b0;
      acc_hi    = 1'b0;
      case (state_ff)
         S_LOAD: begin mul_a = mag_re; mul_b = mag_re; acc_clear = 1'b1; end
         S_P1:   begin mul_a = mag_im; mul_b = mag_im; end
         S_SP0:  begin
            mul_a = SW'(cfg.power_smoothing); mul_b = row_ff.smoothed[SW-1:0];
            acc_clear = 1'b1;
         end
         S_SP1:  begin
            mul_a = SW'(cfg.power_smoothing); mul_b = row_ff.smoothed[PW-1:SW];
            acc_hi = 1'b1;
         end
         S_SP2:  begin mul_a = SW'(ps_inv); mul_b = p_ff[SW-1:0]; end
         S_SP3:  begin mul_a = SW'(ps_inv); mul_b = p_ff[PW-1:SW]; acc_hi = 1'b1; end
         S_B0:   begin
            mul_a = SW'(cfg.noise_bias); mul_b = row_ff.running_min[SW-1:0];
            acc_clear = 1'b1;
         end
         S_B1:   begin
            mul_a = SW'(cfg.noise_bias); mul_b = row_ff.running_min[PW-1:SW];
            acc_hi = 1'b1;
         end
         S_B2:   begin mul_a = row_ff.clean; mul_b = row_ff.clean; acc_clear = 1'b1; end
         S_X1:   begin
            mul_a = SW'(cfg.prior_smoothing); mul_b = cc_ff[SW-1:0]; acc_clear = 1'b1;
         end
         S_X2:   begin
            mul_a = SW'(cfg.prior_smoothing); mul_b = cc_ff[PW-1:SW]; acc_hi = 1'b1;
         end
         S_X3:   begin mul_a = SW'(d_inv); mul_b = ex_ff[SW-1:0]; end
         S_X4:   begin mul_a = SW'(d_inv); mul_b = ex_ff[PW-1:SW]; acc_hi = 1'b1; end
         S_C0:   begin mul_a = SW'(g_ff); mul_b = sq_r_ff[SW-1:0]; acc_clear = 1'b1; end
         S_C1:   begin mul_a = mag_re; mul_b = SW'(g_ff); acc_clear = 1'b1; end
         S_C2:   begin mul_a = mag_im; mul_b = SW'(g_ff); acc_clear = 1'b1; end
         default: acc_en = 1'b0;
      endcase
   end

   always_comb begin
      pop         = (state_ff == S_IDLE) && head_valid;
      clear_busy  = (state_ff == S_CLEAR);
      ram_rd_en   = pop;
      ram_rd_addr = AddrWidth'(head_item.index);
      ram_wr_en   = 1'b0;
      ram_wr_addr = AddrWidth'(cur_ff.index);
      ram_wr_data = row_ff;
      ram_wr_data.clean = acc_ff[SW+GW-1:GW];
      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = row_reset;
         end
         S_WB: begin
            ram_wr_en   = out_free && cur_ff.in_range;
            ram_wr_data.clean = row_ff.clean;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         sq_bit_ff    <= '0;
         div_cnt_ff   <= '0;
      end else begin
         if (acc_en) begin
            acc_ff <= acc_in;
         end
         // square root runs beside the main sequence, one result bit a cycle
         if (state_ff == S_SP0) begin
            sq_v_ff   <= acc_ff[PW-1:0];
            sq_r_ff   <= '0;
            sq_bit_ff <= sng_pkg::PowerOne;
         end else if (sq_bit_ff != '0) begin
            if (sq_v_ff >= sq_trial) begin
               sq_v_ff <= sq_v_ff - sq_trial;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_WB)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AddrWidth'(NumBins-1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (head_valid) begin
                  cur_ff   <= head_item;
                  g_ff     <= '0;
                  ore_ff   <= '0;
                  oim_ff   <= '0;
                  state_ff <= head_item.in_range ? S_LOAD : S_WB;
               end
            end
            S_LOAD: begin
               row_ff   <= ram_rd_data;
               state_ff <= S_P1;
            end
            S_P1:  state_ff <= S_SP0;
            S_SP0: begin
               p_ff     <= acc_ff[PW-1:0];
               state_ff <= S_SP1;
            end
            S_SP1: state_ff <= S_SP2;
            S_SP2: state_ff <= S_SP3;
            S_SP3: state_ff <= S_MIN;
            S_MIN: begin
               row_ff.smoothed <= sp_new;
               if (sp_new < row_ff.running_min) row_ff.running_min <= sp_new;
               if (sp_new < row_ff.spare_min)   row_ff.spare_min   <= sp_new;
               state_ff <= S_B0;
            end
            S_B0: state_ff <= S_B1;
            S_B1: state_ff <= S_B2;
            S_B2: begin
               if (cur_ff.swap) begin
                  row_ff.noise       <= (bias_t[51:PW] != '0) ? sng_pkg::PowerMax
                                                              : bias_t[PW-1:0];
                  row_ff.running_min <= row_ff.spare_min;
                  row_ff.spare_min   <= row_ff.smoothed;
               end
               state_ff <= S_X0;
            end
            S_X0: begin
               cc_ff    <= acc_ff[PW-1:0];
               n_ff     <= (row_ff.noise < sng_pkg::PowerEps) ? sng_pkg::PowerEps
                                                              : row_ff.noise;
               state_ff <= S_X1;
            end
            S_X1: begin
               ex_ff    <= (p_ff > n_ff) ? p_ff - n_ff : '0;
               state_ff <= S_X2;
            end
            S_X2: state_ff <= S_X3;
            S_X3: state_ff <= S_X4;
            S_X4: state_ff <= S_DIV;
            S_DIV: begin
               rem_ff     <= {1'b0, x_val};
               den_ff     <= {1'b0, x_val} + {1'b0, n_ff};
               q_ff       <= '0;
               div_cnt_ff <= '0;
               state_ff   <= S_DIVI;
            end
            S_DIVI: begin
               if (rem2 >= {1'b0, den_ff}) begin
                  rem_ff <= (PW+1)'(rem2 - {1'b0, den_ff});
                  q_ff   <= {q_ff[GW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem2[PW:0];
                  q_ff   <= {q_ff[GW-2:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 4'd15) begin
                  state_ff <= S_GAIN;
               end
            end
            S_GAIN: begin
               // hold until the root is settled
               if (sq_bit_ff == '0) begin
                  g_ff     <= (q_ff < cfg.gain_floor) ? cfg.gain_floor : q_ff;
                  state_ff <= S_C0;
               end
            end
            S_C0: state_ff <= S_C1;
            S_C1: begin
               row_ff.clean <= acc_ff[SW+GW-1:GW];
               state_ff     <= S_C2;
            end
            S_C2: begin
               ore_ff   <= cur_ff.re[SW-1] ? (SW'(0) - m_re) : m_re;
               state_ff <= S_C3;
            end
            S_C3: begin
               oim_ff   <= cur_ff.im[SW-1] ? (SW'(0) - m_im) : m_im;
               state_ff <= S_WB;
            end
            S_WB: begin
               // a result still waiting is released in this same cycle when out_free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= cur_ff.index;
                  rsp_real_ff  <= ore_ff;
                  rsp_imag_ff  <= oim_ff;
                  rsp_gain_ff  <= g_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_real  = rsp_real_ff;
   assign rsp_out_imag  = rsp_imag_ff;
   assign rsp_bin_gain  = rsp_gain_ff;

endmodule

// File: rtl/spectral_noise_gain_engine_top.sv
// An in-range bin is read from state memory and steps through the power,
//   minimum, bias, prior, divider, gain and scaling states; out-of-range bins
//   go straight to write-back, which waits while a result is not taken.
// Throughput: one bin at a time via the shared multiply-accumulate and the
//   16-step gain divider; the queue takes up to two more. Reset: synchronous;
//   then a clearing pass fills state memory; only register writes are taken.
// ----------------------------------------------------------------------------
// spectral_noise_gain_engine_top: per-bin noise suppression gain engine
// Front classifies bins and counts frames, a queue decouples it from the
// back sequencer that updates noise state and scales each bin.
// ----------------------------------------------------------------------------
module spectral_noise_gain_engine_top #(
   parameter int NUM_BINS = sng_pkg::NumBinsDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [sng_pkg::IndexWidth-1:0]         req_bin_index,
   input  logic signed [sng_pkg::SampleWidth-1:0] req_bin_real,
   input  logic signed [sng_pkg::SampleWidth-1:0] req_bin_imag,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sng_pkg::IndexWidth-1:0]         rsp_out_index,
   output logic signed [sng_pkg::SampleWidth-1:0] rsp_out_real,
   output logic signed [sng_pkg::SampleWidth-1:0] rsp_out_imag,
   output logic [sng_pkg::GainWidth-1:0]          rsp_bin_gain,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sng_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [sng_pkg::CsrDataWidth-1:0]       csr_data
);

   localparam int AddrWidth = $clog2(NUM_BINS);

   sng_pkg::cfg_type       cfg;
   sng_pkg::item_type      push_item;
   sng_pkg::item_type      head_item;
   sng_pkg::row_type       ram_wr_data;
   sng_pkg::row_type       ram_rd_data;
   logic                   push_valid;
   logic                   push_ready;
   logic                   head_valid;
   logic                   pop;
   logic                   clear_busy;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [AddrWidth-1:0]   ram_wr_addr;
   logic [AddrWidth-1:0]   ram_rd_addr;

   sng_front #(.NumBins(NUM_BINS)) u_front (
      .clock, .reset,
      .req_valid, .req_ready, .req_bin_index, .req_bin_real, .req_bin_imag,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .clear_busy, .cfg,
      .push_valid, .push_ready, .push_item
   );

   sng_fifo u_fifo (
      .clock, .reset,
      .push_valid, .push_ready, .push_item,
      .pop_valid(head_valid), .pop, .pop_item(head_item)
   );

   sng_ram #(
      .Width($bits(sng_pkg::row_type)),
      .Depth(NUM_BINS)
   ) u_state_ram (
      .clock,
      .wr_en(ram_wr_en), .wr_addr(ram_wr_addr), .wr_data(ram_wr_data),
      .rd_en(ram_rd_en), .rd_addr(ram_rd_addr), .rd_data(ram_rd_data)
   );

   sng_back #(.NumBins(NUM_BINS)) u_back (
      .clock, .reset, .cfg,
      .head_valid, .head_item, .pop, .clear_busy,
      .ram_wr_en, .ram_wr_addr, .ram_wr_data,
      .ram_rd_en, .ram_rd_addr, .ram_rd_data,
      .rsp_valid, .rsp_ready, .rsp_out_index, .rsp_out_real, .rsp_out_imag,
      .rsp_bin_gain
   );

endmodule
